### hdl/proximity_alarm_controller_defines.svh
// Assertion macros shared by the proximity alarm controller RTL.
`ifndef PROXIMITY_ALARM_CONTROLLER_DEFINES_SVH
`define PROXIMITY_ALARM_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PAC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PAC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pac assertion failed");

`else

`define PAC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define PAC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### hdl/pac_pkg.sv
// Shared types, constants and helper functions of the proximity alarm controller.
package pac_pkg;

  localparam int SAMPLE_SHIFT = 2;
  localparam int SAMPLE_COUNT = 1 << SAMPLE_SHIFT;
  localparam int IDX_W        = SAMPLE_SHIFT;
  localparam int TIME_W       = 16;
  localparam int SUM_W        = TIME_W + SAMPLE_SHIFT;
  localparam int FUNC_W       = 3;

  localparam logic [TIME_W-1:0] TOL_RESET = 16'd100;

  localparam logic [FUNC_W-1:0] FUNC_ARM   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RISE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FALL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd4;

  localparam logic [1:0] CODE_IDLE      = 2'd0;
  localparam logic [1:0] CODE_ARMING    = 2'd1;
  localparam logic [1:0] CODE_SET       = 2'd2;
  localparam logic [1:0] CODE_TRIGGERED = 2'd3;

  // Bit 0 is the first indicator, bit 1 the second.
  localparam logic [1:0] LED_IDLE   = 2'b01;
  localparam logic [1:0] LED_ARMING = 2'b11;
  localparam logic [1:0] LED_SET    = 2'b10;
  localparam logic [1:0] LED_TOGGLE = 2'b11;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_ARMING    = 4'b0010,
    MODE_SET       = 4'b0100,
    MODE_TRIGGERED = 4'b1000
  } mode_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] last_width;
  } meas_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } arm_cmd_t;

  typedef struct packed {
    logic done;
    logic ok;
    logic width_ok;
  } arm_stat_t;

  function automatic logic within_tol(input logic [TIME_W-1:0] w,
                                      input logic [TIME_W-1:0] avg,
                                      input logic [TIME_W-1:0] tol);
    logic [TIME_W-1:0] diff;
    diff = (w >= avg) ? (w - avg) : (avg - w);
    return diff < tol;
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    case (m)
      MODE_IDLE:      code = CODE_IDLE;
      MODE_ARMING:    code = CODE_ARMING;
      MODE_SET:       code = CODE_SET;
      MODE_TRIGGERED: code = CODE_TRIGGERED;
      default:        code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### hdl/proximity_alarm_controller.sv
// Top level of the proximity alarm controller: handshake, mode control and indicators.
//
// Input channel: one word per event (in_func, in_capture_time) under in_valid and
// in_stall. Result channel: one word per event under out_valid and out_stall,
// carrying the mode, both indicator levels, the width flag, the last pulse width
// and the armed reference, all as they stand after that event.
// Configuration: cfg_we writes cfg_wdata into the tolerance register; write it
// only while no event is in flight.
// Path: an accepted event is captured in the input register; it is processed when
// the result register is empty or its word is taken, which loads the result
// register with the event's result word.
// Throughput: one event per cycle unless the receiver stalls; the whole update,
// including the four-sample average and tolerance compare, is combinational
// logic between the two registers.
// Reset (rst_n low, synchronous): idle mode, first indicator on, no rise pending,
// widths and reference zero, tolerance 100, both channels empty.
// When the receiver stalls, the result word holds; the input register still
// takes one more event, and then in_stall rises until the result is taken.
module proximity_alarm_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pac_pkg::FUNC_W-1:0] in_func,
  input  logic [pac_pkg::TIME_W-1:0] in_capture_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_mode,
  output logic                       out_led_first,
  output logic                       out_led_second,
  output logic                       out_width_valid,
  output logic [pac_pkg::TIME_W-1:0] out_pulse_width,
  output logic [pac_pkg::TIME_W-1:0] out_reference,
  input  logic                       cfg_we,
  input  logic [pac_pkg::TIME_W-1:0] cfg_wdata
);
  import pac_pkg::*;
  `include "proximity_alarm_controller_defines.svh"

  logic              stage_valid_r, stage_valid_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [TIME_W-1:0] cap_r;
  logic [TIME_W-1:0] tol_r, tol_nxt;
  mode_t             mode_r, mode_nxt;
  logic [1:0]        led_r, led_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        mode_out_r;
  logic [1:0]        led_out_r;
  logic              width_valid_r;
  logic [TIME_W-1:0] pulse_width_r;
  logic [TIME_W-1:0] reference_r;
  logic              advance;
  logic              in_take;
  meas_t             meas;
  arm_cmd_t          cmd;
  arm_stat_t         stat;
  logic [TIME_W-1:0] average;

  assign advance  = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stage_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  pac_width u_width (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .func         (func_r),
    .capture_time (cap_r),
    .meas         (meas)
  );

  assign cmd.clear  = advance && (mode_r == MODE_IDLE) && (func_r == FUNC_ARM);
  assign cmd.sample = advance && (mode_r == MODE_ARMING) && meas.valid;

  pac_arming u_arming (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .width     (meas.last_width),
    .tolerance (tol_r),
    .stat      (stat),
    .average   (average)
  );

  always_comb begin
    mode_nxt = mode_r;
    led_nxt  = led_r;
    if (advance) begin
      case (mode_r)
        MODE_IDLE: begin
          if (func_r == FUNC_ARM) begin
            mode_nxt = MODE_ARMING;
            led_nxt  = LED_ARMING;
          end
        end
        MODE_ARMING: begin
          if (stat.done && stat.ok) begin
            mode_nxt = MODE_SET;
            led_nxt  = LED_SET;
          end else if (stat.done) begin
            mode_nxt = MODE_IDLE;
            led_nxt  = LED_IDLE;
          end
        end
        MODE_SET: begin
          if (func_r == FUNC_RESET) begin
            mode_nxt = MODE_IDLE;
            led_nxt  = LED_IDLE;
          end else if (meas.valid && !stat.width_ok) begin
            // The indicators keep the set pattern until the first tick.
            mode_nxt = MODE_TRIGGERED;
          end
        end
        MODE_TRIGGERED: begin
          if (func_r == FUNC_RESET) begin
            mode_nxt = MODE_IDLE;
            led_nxt  = LED_IDLE;
          end else if (func_r == FUNC_TICK) begin
            led_nxt = led_r ^ LED_TOGGLE;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          led_nxt  = LED_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    tol_nxt         = cfg_we ? cfg_wdata : tol_r;
    stage_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : stage_valid_r);
    out_valid_nxt   = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= MODE_IDLE;
      led_r         <= LED_IDLE;
      tol_r         <= TOL_RESET;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      mode_r        <= mode_nxt;
      led_r         <= led_nxt;
      tol_r         <= tol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      cap_r  <= in_capture_time;
    end
    if (advance) begin
      mode_out_r    <= mode_code(mode_nxt);
      led_out_r     <= led_nxt;
      width_valid_r <= meas.valid;
      pulse_width_r <= meas.last_width;
      reference_r   <= average;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mode        = mode_out_r;
  assign out_led_first   = led_out_r[0];
  assign out_led_second  = led_out_r[1];
  assign out_width_valid = width_valid_r;
  assign out_pulse_width = pulse_width_r;
  assign out_reference   = reference_r;

  `PAC_ASSERT_NOW(a_idle_leds, clk, rst_n, mode_r == MODE_IDLE, led_r == LED_IDLE)
  `PAC_ASSERT_NOW(a_armed_second_on, clk, rst_n, mode_r == MODE_ARMING || mode_r == MODE_SET, led_r[1])
  `PAC_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !advance)
  `PAC_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, out_valid_r)

endmodule

### hdl/pac_width.sv
// Echo pulse width measurement from rise and fall capture times.
module pac_width (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [pac_pkg::FUNC_W-1:0] func,
  input  logic [pac_pkg::TIME_W-1:0] capture_time,
  output pac_pkg::meas_t             meas
);
  import pac_pkg::*;

  logic              rise_seen_r, rise_seen_nxt;
  logic [TIME_W-1:0] rise_time_r, rise_time_nxt;
  logic [TIME_W-1:0] last_width_r, last_width_nxt;
  logic              fall_hit;
  logic [TIME_W-1:0] new_width;

  always_comb begin
    fall_hit       = (func == FUNC_FALL) && rise_seen_r;
    // Timer wrap is handled by the modular subtraction.
    new_width      = capture_time - rise_time_r;
    rise_seen_nxt  = rise_seen_r;
    rise_time_nxt  = rise_time_r;
    last_width_nxt = last_width_r;
    if (step) begin
      if (func == FUNC_RISE) begin
        rise_seen_nxt = 1'b1;
        rise_time_nxt = capture_time;
      end else if (fall_hit) begin
        rise_seen_nxt  = 1'b0;
        last_width_nxt = new_width;
      end
    end
    meas.valid      = fall_hit;
    meas.last_width = fall_hit ? new_width : last_width_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_seen_r  <= 1'b0;
      rise_time_r  <= '0;
      last_width_r <= '0;
    end else begin
      rise_seen_r  <= rise_seen_nxt;
      rise_time_r  <= rise_time_nxt;
      last_width_r <= last_width_nxt;
    end
  end

endmodule

### hdl/pac_arming.sv
// Sample collection, averaging and tolerance checks for arming and set modes.
module pac_arming (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pac_pkg::arm_cmd_t          cmd,
  input  logic [pac_pkg::TIME_W-1:0] width,
  input  logic [pac_pkg::TIME_W-1:0] tolerance,
  output pac_pkg::arm_stat_t         stat,
  output logic [pac_pkg::TIME_W-1:0] average
);
  import pac_pkg::*;

  logic [TIME_W-1:0] samples_r [SAMPLE_COUNT];
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TIME_W-1:0] avg_r, avg_nxt;
  logic [SUM_W-1:0]  sum_full;
  logic [TIME_W-1:0] avg_new;
  logic [TIME_W-1:0] val;
  logic              done;
  logic              all_ok;

  always_comb begin
    sum_full = sum_r + SUM_W'(width);
    avg_new  = sum_full[SUM_W-1:SAMPLE_SHIFT];
    done     = cmd.sample && (cnt_r == IDX_W'(SAMPLE_COUNT - 1));
    // The newest width is not yet stored, so it stands in for its slot.
    all_ok   = 1'b1;
    val      = '0;
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      val = (IDX_W'(k) == cnt_r) ? width : samples_r[k];
      if (!within_tol(val, avg_new, tolerance)) begin
        all_ok = 1'b0;
      end
    end
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    avg_nxt = avg_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
      sum_nxt = '0;
    end else if (done) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      avg_nxt = avg_new;
    end else if (cmd.sample) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_full;
    end
    stat.done     = done;
    stat.ok       = all_ok;
    stat.width_ok = within_tol(width, avg_r, tolerance);
    average       = avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      avg_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      avg_r <= avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      samples_r[cnt_r] <= width;
    end
  end

endmodule

### test/pac_monitor.sv
// Result checker for the proximity alarm controller: predicts each result word and compares.
module pac_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [pac_pkg::FUNC_W-1:0] in_func,
  input  logic [pac_pkg::TIME_W-1:0] in_capture_time,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_mode,
  input  logic                       out_led_first,
  input  logic                       out_led_second,
  input  logic                       out_width_valid,
  input  logic [pac_pkg::TIME_W-1:0] out_pulse_width,
  input  logic [pac_pkg::TIME_W-1:0] out_reference,
  input  logic                       cfg_we,
  input  logic [pac_pkg::TIME_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         pending
);
  import pac_pkg::*;

  typedef struct packed {
    logic [1:0]        mode;
    logic              led_first;
    logic              led_second;
    logic              width_valid;
    logic [TIME_W-1:0] pulse_width;
    logic [TIME_W-1:0] reference;
  } alarm_status_t;

  alarm_status_t status_q[$];
  int            err_count = 0;
  int            queued = 0;

  // Predicted controller state.
  logic [TIME_W-1:0] tol_r;
  logic [1:0]        mode_r;
  logic [1:0]        leds_r;
  logic              rise_pend;
  logic [TIME_W-1:0] rise_t;
  logic [TIME_W-1:0] samp [SAMPLE_COUNT];
  logic [2:0]        n_samp;
  logic [SUM_W-1:0]  samp_sum;
  logic [TIME_W-1:0] avg_r;
  logic [TIME_W-1:0] last_w;

  assign mismatches = err_count;
  assign pending    = queued;

  function automatic logic near_reference(input logic [TIME_W-1:0] w);
    logic [TIME_W-1:0] diff_w;
    diff_w = (w >= avg_r) ? w - avg_r : avg_r - w;
    return diff_w < tol_r;
  endfunction

  task automatic go_mode(input logic [1:0] m);
    mode_r = m;
    case (m)
      CODE_IDLE:   leds_r = LED_IDLE;
      CODE_ARMING: leds_r = LED_ARMING;
      CODE_SET:    leds_r = LED_SET;
      default:     ; // triggered keeps the set pattern until a tick
    endcase
  endtask

  task automatic step_alarm(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] cap,
                            output alarm_status_t s);
    logic all_ok;
    logic done;
    done = 1'b0;
    case (f)
      FUNC_ARM:
        if (mode_r == CODE_IDLE) begin
          n_samp   = '0;
          samp_sum = '0;
          go_mode(CODE_ARMING);
        end
      FUNC_RESET:
        if (mode_r == CODE_SET || mode_r == CODE_TRIGGERED) go_mode(CODE_IDLE);
      FUNC_RISE: begin
        rise_t    = cap;
        rise_pend = 1'b1;
      end
      FUNC_FALL:
        if (rise_pend) begin
          last_w    = cap - rise_t;
          rise_pend = 1'b0;
          done      = 1'b1;
          if (mode_r == CODE_ARMING) begin
            if (n_samp < SAMPLE_COUNT) begin
              samp[n_samp[IDX_W-1:0]] = last_w;
              samp_sum = samp_sum + last_w;
              n_samp   = n_samp + 1'b1;
            end
            if (n_samp >= SAMPLE_COUNT) begin
              avg_r  = samp_sum / SAMPLE_COUNT;
              all_ok = 1'b1;
              for (int k = 0; k < SAMPLE_COUNT; k++)
                if (!near_reference(samp[k])) all_ok = 1'b0;
              n_samp   = '0;
              samp_sum = '0;
              go_mode(all_ok ? CODE_SET : CODE_IDLE);
            end
          end else if (mode_r == CODE_SET && !near_reference(last_w)) begin
            go_mode(CODE_TRIGGERED);
          end
        end
      FUNC_TICK:
        if (mode_r == CODE_TRIGGERED) leds_r = leds_r ^ LED_TOGGLE;
      default: ;
    endcase
    s.mode        = mode_r;
    s.led_first   = leds_r[0];
    s.led_second  = leds_r[1];
    s.width_valid = done;
    s.pulse_width = last_w;
    s.reference   = avg_r;
  endtask

  always @(posedge clk) begin : watch
    alarm_status_t got;
    alarm_status_t want;
    if (!rst_n) begin
      tol_r     = TOL_RESET;
      mode_r    = CODE_IDLE;
      leds_r    = LED_IDLE;
      rise_pend = 1'b0;
      rise_t    = '0;
      n_samp    = '0;
      samp_sum  = '0;
      avg_r     = '0;
      last_w    = '0;
      status_q.delete();
    end else begin
      if (cfg_we) tol_r = cfg_wdata;
      if (out_valid && !out_stall) begin
        got = '{out_mode, out_led_first, out_led_second, out_width_valid,
                out_pulse_width, out_reference};
        if (status_q.size() == 0) begin
          if (err_count < 10)
            $display("unexpected word: mode %0d leds %0b%0b wv %0b width %0d ref %0d",
                     got.mode, got.led_first, got.led_second, got.width_valid,
                     got.pulse_width, got.reference);
          err_count++;
        end else begin
          want = status_q.pop_front();
          if (got.mode !== want.mode || got.led_first !== want.led_first ||
              got.led_second !== want.led_second || got.width_valid !== want.width_valid ||
              got.pulse_width !== want.pulse_width || got.reference !== want.reference) begin
            if (err_count < 10)
              $display("mismatch: exp %0d %0b%0b %0b %0d %0d, got %0d %0b%0b %0b %0d %0d",
                       want.mode, want.led_first, want.led_second, want.width_valid,
                       want.pulse_width, want.reference,
                       got.mode, got.led_first, got.led_second, got.width_valid,
                       got.pulse_width, got.reference);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_alarm(in_func, in_capture_time, want);
        status_q.push_back(want);
      end
    end
    queued = status_q.size();
  end

endmodule

### test/tb_proximity_alarm_controller.sv
// Testbench top for the proximity alarm controller: stimulus, handshake pacing and verdict.
module tb_proximity_alarm_controller;
  import pac_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_EVENTS  = 250;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [TIME_W-1:0] in_capture_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_mode;
  logic              out_led_first;
  logic              out_led_second;
  logic              out_width_valid;
  logic [TIME_W-1:0] out_pulse_width;
  logic [TIME_W-1:0] out_reference;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;
  int                mismatches;
  int                pending;

  int events_sent = 0;
  int burst_left = 0;
  int cur_tol = TOL_RESET;
  int cycles = 0;
  int stall_style = 0;

  proximity_alarm_controller dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_capture_time(in_capture_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mode       (out_mode),
    .out_led_first  (out_led_first),
    .out_led_second (out_led_second),
    .out_width_valid(out_width_valid),
    .out_pulse_width(out_pulse_width),
    .out_reference  (out_reference),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  pac_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_capture_time(in_capture_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mode       (out_mode),
    .out_led_first  (out_led_first),
    .out_led_second (out_led_second),
    .out_width_valid(out_width_valid),
    .out_pulse_width(out_pulse_width),
    .out_reference  (out_reference),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("proximity_alarm_controller test failed");
      $finish;
    end
  end

  // The receiver switches at random between stall styles.
  always @(negedge clk) begin
    if (cycles % 200 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycles % 7 < 3);
    endcase
  end

  function automatic logic [TIME_W-1:0] any_time();
    return $urandom_range(0, 65535);
  endfunction

  // Drives one word at the falling edge and holds it until the block takes it.
  task automatic send_event(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] cap);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        = 1'b1;
    in_func         = f;
    in_capture_time = cap;
    do @(posedge clk); while (in_stall);
    events_sent++;
  endtask

  task automatic send_echo(input logic [TIME_W-1:0] rise_at, input logic [TIME_W-1:0] width);
    send_event(FUNC_RISE, rise_at);
    send_event(FUNC_FALL, rise_at + width);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_tolerance(input int value);
    drain();
    // Every event yields a word, so once no word is pending the pipeline is empty.
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_tol   = value;
  endtask

  task automatic random_noise();
    int n;
    n = $urandom_range(3, 15);
    repeat (n) send_event($urandom_range(0, 7), any_time());
  endtask

  // One arm, measure and watch sequence with widths clustered around a base.
  task automatic alarm_sequence();
    int jit, base, bad, n, pick, w;
    jit = (cur_tol - 1) / 2;
    if (jit > 2000) jit = 2000;
    base = $urandom_range(jit, 65535 - jit);
    bad  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SAMPLE_COUNT - 1) : -1;
    send_event(FUNC_RESET, any_time());
    send_event(FUNC_ARM, any_time());
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      w = (k == bad) ? any_time() : base - jit + $urandom_range(0, 2 * jit);
      send_echo(any_time(), w);
    end
    n = $urandom_range(0, 6);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       send_echo(any_time(), base - jit + $urandom_range(0, 2 * jit));
      else if (pick == 6) send_event(FUNC_TICK, any_time());
      else if (pick == 7) send_event($urandom_range(0, 7), any_time());
      else if (pick == 8) send_echo(any_time(), any_time());
      else                send_event(FUNC_RISE, any_time());
    end
    if ($urandom_range(0, 1) == 1)
      send_echo(any_time(), base + jit + cur_tol + $urandom_range(0, 50));
    n = $urandom_range(0, 5);
    repeat (n) send_event(FUNC_TICK, any_time());
    if ($urandom_range(0, 3) == 0) send_echo(any_time(), any_time());
    if ($urandom_range(0, 1) == 1) send_event(FUNC_RESET, any_time());
  endtask

  initial begin : stimulus
    int tol_plan [6];
    int target;
    tol_plan = '{1, 65535, 0, 0, 0, 100};
    tol_plan[2] = $urandom_range(2, 400);
    tol_plan[3] = $urandom_range(1, 65535);
    tol_plan[4] = $urandom_range(20, 3000);

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed pass at the reset tolerance.
    send_event(FUNC_SPARE_A, 16'hFFFF);
    send_event(FUNC_SPARE_B, 16'h0000);
    send_event(FUNC_SPARE_C, 16'hA5A5);
    send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_RESET, 16'hFFFF);
    send_event(FUNC_FALL, 16'h1234);
    send_event(FUNC_RISE, 16'hFFF0);
    send_event(FUNC_RISE, 16'hFFFF);
    send_event(FUNC_FALL, 16'h0000);
    send_echo(16'h0000, 16'hFFFF);
    send_event(FUNC_ARM, 16'h0000);
    send_event(FUNC_RESET, 16'h0000);
    send_event(FUNC_ARM, 16'hFFFF);
    send_echo(16'h0100, 16'd1000);
    send_echo(16'hFF00, 16'd1000);
    send_echo(16'h5555, 16'd1000);
    send_echo(16'hAAAA, 16'd1000);
    send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_ARM, 16'h0000);
    send_echo(16'h7FFF, 16'd5000);
    send_event(FUNC_TICK, 16'hFFFF);
    send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_RESET, 16'h0000);

    foreach (tol_plan[p]) begin
      write_tolerance(tol_plan[p]);
      target = events_sent + PHASE_EVENTS;
      while (events_sent < target) begin
        if ($urandom_range(0, 4) == 0) random_noise();
        else alarm_sequence();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("proximity_alarm_controller test passed");
    else
      $display("proximity_alarm_controller test failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pac_pkg.sv
hdl/pac_width.sv
hdl/pac_arming.sv
hdl/proximity_alarm_controller.sv
test/pac_monitor.sv
test/tb_proximity_alarm_controller.sv
